FILE: rtl/assert_macros.svh
// assertion macros for the rtl core
// depends on nothing; included by topk_newest_slot_keeper_core.sv, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while the active-low reset is asserted
`define TNSK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define TNSK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tnsk_pkg.sv
// package for the top-k newest slot keeper
// holds shared widths and default constants; no dependencies
package tnsk_pkg;

  localparam int unsigned SlotsDefault = 256;
  localparam int unsigned StampW       = 64;
  localparam int unsigned CapW         = 9;
  localparam int unsigned SlotOutW     = 8;
  localparam logic [CapW-1:0] CapReset = CapW'(256);

endpackage

FILE: rtl/tnsk_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module tnsk_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tnsk_scan.sv
// minimum scan over the first count entries of the stamp ram
// depends on tnsk_pkg; drives the ram read port, one entry per cycle
module tnsk_scan
  import tnsk_pkg::*;
#(
  parameter int unsigned Slots = SlotsDefault,
  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1,
  localparam int unsigned CntW = $clog2(Slots + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CntW-1:0]   count_i,
  output logic [IdxW-1:0]   raddr_o,
  input  logic [StampW-1:0] rdata_i,
  output logic              done_o,
  output logic [IdxW-1:0]   min_slot_o,
  output logic [StampW-1:0] min_stamp_o
);

  typedef enum logic {SC_IDLE, SC_RUN} scan_state_e;

  scan_state_e       state_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [IdxW-1:0]   last_q;
  logic              dvalid_q;
  logic [IdxW-1:0]   didx_q;
  logic              done_q;
  logic [IdxW-1:0]   min_slot_q;
  logic [StampW-1:0] min_stamp_q;
  logic              take_new;

  // first entry always loads; later ones only when strictly smaller (lowest slot wins ties)
  assign take_new = (didx_q == '0) || ($signed(rdata_i) < $signed(min_stamp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SC_IDLE;
      rd_idx_q <= '0;
      last_q   <= '0;
      dvalid_q <= 1'b0;
      didx_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      // read data shows up in the cycle after each address of the run
      dvalid_q <= (state_q == SC_RUN);
      done_q   <= dvalid_q && (didx_q == last_q);
      case (state_q)
        SC_IDLE: begin
          if (start_i) begin
            rd_idx_q <= '0;
            last_q   <= IdxW'(count_i - CntW'(1));
            state_q  <= SC_RUN;
          end
        end
        SC_RUN: begin
          didx_q   <= rd_idx_q;
          if (rd_idx_q == last_q) begin
            state_q <= SC_IDLE;
          end else begin
            rd_idx_q <= rd_idx_q + IdxW'(1);
          end
        end
        default: state_q <= SC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (dvalid_q && take_new) begin
      min_stamp_q <= rdata_i;
      min_slot_q  <= didx_q;
    end
  end

  assign raddr_o     = rd_idx_q;
  assign done_o      = done_q;
  assign min_slot_o  = min_slot_q;
  assign min_stamp_o = min_stamp_q;

endmodule

FILE: rtl/topk_newest_slot_keeper_core.sv
// top level of the top-k newest slot keeper
// depends on tnsk_pkg, tnsk_ram, tnsk_scan and assert_macros.svh
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   input    | in_valid_i, in_ready_o, stamp_i      | in
//   result   | out_valid_o, out_ready_i,            | out
//            |   accepted_o, slot_o                 |
//   config   | cfg_we_i, cfg_wdata_i (capacity)     | in
//
// one item at a time; in_ready_o is high only while no item is in work
// filling a free slot: accept, then hand to the output register once it is free
// full table: accept, then scan, then hand to the output register; the scan reads
//   one ram entry per cycle through the single read port
// reset clears control state and sets capacity to 256; the ram is not cleared,
//   only slots below the fill count are ever read
// a stalled output register holds the finished item; the next item waits for it
`include "assert_macros.svh"

module topk_newest_slot_keeper_core
  import tnsk_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [StampW-1:0] stamp_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     accepted_o,
  output logic [SlotOutW-1:0]      slot_o,
  input  logic                     cfg_we_i,
  input  logic [CapW-1:0]          cfg_wdata_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PUSH} core_state_e;

  core_state_e        state_q;
  logic [CapW-1:0]    cap_q;
  logic [CntW-1:0]    filled_q;
  logic [StampW-1:0]  stamp_q;
  logic               pend_acc_q;
  logic [IdxW-1:0]    pend_slot_q;
  logic               out_valid_q;
  logic               accepted_q;
  logic [SlotOutW-1:0] slot_q;

  logic [CmpW-1:0]    eff_cap;
  logic               has_room;
  logic               in_fire;
  logic               out_free;

  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [StampW-1:0]  ram_wdata;
  logic [IdxW-1:0]    ram_raddr;
  logic [StampW-1:0]  ram_rdata;

  logic               scan_start;
  logic               scan_done;
  logic [IdxW-1:0]    min_slot;
  logic [StampW-1:0]  min_stamp;
  logic               replace;

  // capacity of zero acts as one, above SLOTS it saturates
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(SLOTS)) begin
      eff_cap = CmpW'(SLOTS);
    end else begin
      eff_cap = CmpW'(cap_q);
    end
  end

  assign has_room   = CmpW'(filled_q) < eff_cap;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign scan_start = in_fire && !has_room;

  // new stamp must be strictly newer than the oldest kept one
  assign replace = $signed(stamp_q) > $signed(min_stamp);

  // ram write: free slot on accept, or the oldest slot when the scan says so
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = min_slot;
    ram_wdata = stamp_q;
    if (in_fire && has_room) begin
      ram_we    = 1'b1;
      ram_waddr = IdxW'(filled_q);
      ram_wdata = stamp_i;
    end else if (state_q == ST_SCAN && scan_done && replace) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapReset;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      // output register: load a finished item, or empty it once taken
      if (state_q == ST_PUSH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (has_room) begin
              filled_q <= filled_q + CntW'(1);
              state_q  <= ST_PUSH;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stamp_q     <= stamp_i;
      pend_acc_q  <= has_room;
      pend_slot_q <= IdxW'(filled_q);
    end
    if (state_q == ST_SCAN && scan_done) begin
      pend_acc_q  <= replace;
      pend_slot_q <= replace ? min_slot : '0;
    end
    if (state_q == ST_PUSH && out_free) begin
      accepted_q <= pend_acc_q;
      slot_q     <= SlotOutW'(pend_slot_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign slot_o      = slot_q;

  tnsk_ram #(
    .Width (StampW),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tnsk_scan #(
    .Slots (SLOTS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .count_i     (filled_q),
    .raddr_o     (ram_raddr),
    .rdata_i     (ram_rdata),
    .done_o      (scan_done),
    .min_slot_o  (min_slot),
    .min_stamp_o (min_stamp)
  );

  // fill count never runs past the table
  `TNSK_ASSERT(a_filled_bound, clk_i, rst_ni, (CmpW'(filled_q) <= CmpW'(SLOTS)), "filled above SLOTS")
  // a scan only finishes while an item waits on it
  `TNSK_ASSERT(a_done_in_scan, clk_i, rst_ni, (scan_done |-> state_q == ST_SCAN), "stray scan done")
  // an item that finds a free slot goes straight to the output stage
  `TNSK_ASSERT(a_fill_push, clk_i, rst_ni, (in_fire && has_room |=> state_q == ST_PUSH), "fill path")
  // a rejected item reports slot zero
  `TNSK_ASSERT(a_reject_slot, clk_i, rst_ni, (out_valid_o && !accepted_o |-> slot_o == '0), "reject slot")

endmodule
